>>> rtl/lz78_dictionary_hash_table_top_assert.svh
// Assertion macros for the LZ78 dictionary hash table.
// Included by the top level; needs no package.
`ifndef LZ78_DICTIONARY_HASH_TABLE_TOP_ASSERT_SVH
`define LZ78_DICTIONARY_HASH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define LZDH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lz78 dictionary assertion failed");
// Next-cycle implication, disabled during reset.
`define LZDH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lz78 dictionary assertion failed");
`else
`define LZDH_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define LZDH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/lz78dh_pkg.sv
// Shared constants and types of the LZ78 dictionary hash table.
// Used by the hash unit and the top level; depends on nothing.
package lz78dh_pkg;

   localparam int ROW_BITS   = 14;
   localparam int TABLE_ROWS = 1 << ROW_BITS;
   localparam int COUNT_W    = ROW_BITS + 1;
   localparam int LABEL_W    = 14;
   localparam int SYM_W      = 8;
   localparam int KEY_W      = LABEL_W + SYM_W + 2;

   localparam logic [LABEL_W-1:0]  ROOT_LABEL  = LABEL_W'(256);
   localparam logic [SYM_W-1:0]    SYM_LAST    = SYM_W'(255);
   localparam logic [31:0]         GOLDEN_FRAC = 32'd2654435769;
   localparam logic [COUNT_W-1:0]  COUNT_FULL  = COUNT_W'(TABLE_ROWS);
   localparam logic [ROW_BITS:0]   FOLD_MOD    = (ROW_BITS + 1)'(TABLE_ROWS - 1);

   typedef enum logic [1:0] {
      CMD_SEARCH  = 2'd0,
      CMD_INSERT  = 2'd1,
      CMD_REBUILD = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [LABEL_W-1:0] parent;
      logic [SYM_W-1:0]   symbol;
      logic [LABEL_W-1:0] label;
   } entry_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] base;
      logic [ROW_BITS-1:0] step;
   } hash_type;

endpackage

>>> rtl/lz78dh_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lz78dh_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lz78dh_hash.sv
// Hash unit: base slot by fixed-point multiplicative hashing and probe step.
// Depends on lz78dh_pkg.
module lz78dh_hash (
   input  logic [lz78dh_pkg::KEY_W-1:0] key,
   input  logic                         double_hash_mode,
   output lz78dh_pkg::hash_type         hash
);

   logic [31:0]                   frac;
   logic [lz78dh_pkg::ROW_BITS:0] fold;
   logic [lz78dh_pkg::ROW_BITS:0] rem;

   // fractional part of key * golden ratio, 0.32 fixed point
   assign frac = 32'(key) * lz78dh_pkg::GOLDEN_FRAC;

   // key mod (rows - 1): fold the high part onto the low part, then one correction
   assign fold = (lz78dh_pkg::ROW_BITS + 1)'(key[lz78dh_pkg::ROW_BITS-1:0])
               + (lz78dh_pkg::ROW_BITS + 1)'(key[lz78dh_pkg::KEY_W-1:lz78dh_pkg::ROW_BITS]);
   assign rem  = (fold >= lz78dh_pkg::FOLD_MOD) ? fold - lz78dh_pkg::FOLD_MOD : fold;

   assign hash.base = frac[31 -: lz78dh_pkg::ROW_BITS];
   assign hash.step = double_hash_mode
                    ? (rem[lz78dh_pkg::ROW_BITS-1:0] | lz78dh_pkg::ROW_BITS'(1))
                    : lz78dh_pkg::ROW_BITS'(1);

endmodule

>>> rtl/lz78_dictionary_hash_table_top.sv
// LZ78 dictionary hash table, top level.
// Depends on lz78dh_pkg, lz78dh_hash, lz78dh_ram and the assertion header.
`include "lz78_dictionary_hash_table_top_assert.svh"

// The dictionary keeps 16384 entries of {parent, symbol, label} in one
// synchronous RAM and answers three commands: search, insert and rebuild
// (clear plus reload of the 256 root symbols). Every request gives exactly
// one response. After reset the block sweeps the RAM to zero, one entry per
// cycle; req_stall stays high during that sweep, while configuration writes
// are taken at any time. A search or insert passes through one hash state,
// then one probe per cycle, set by the single RAM read port with its
// registered read, then the load of the output register, which waits while
// a held response is stalled. The number of probes is 1 on a lightly loaded
// table and at most 16384. Rebuild clears all 16384 rows, then hashes and
// probes each of the 256 root inserts in turn, then loads the output
// register. Unused command code 3 goes straight to the response state and
// answers with all fields zero. The response sits in an output register,
// so the next request is taken while it waits for the consumer. The single
// configuration bit selects double hashing (1, reset value) or linear probing
// (0) and should only change while the block is idle.
module lz78_dictionary_hash_table_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_cmd,
   input  logic [lz78dh_pkg::LABEL_W-1:0] req_parent_label,
   input  logic [lz78dh_pkg::SYM_W-1:0]   req_symbol,
   input  logic [lz78dh_pkg::LABEL_W-1:0] req_new_label,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_found,
   output logic [lz78dh_pkg::LABEL_W-1:0] rsp_match_label,
   output logic                           rsp_table_full,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_wdata
);

   // FSM and command
   lz78dh_pkg::state_type state_ff, state_in;
   lz78dh_pkg::cmd_type   op_ff, op_in;

   // request fields held for the whole operation
   logic [lz78dh_pkg::LABEL_W-1:0]  parent_ff, parent_in;
   logic [lz78dh_pkg::SYM_W-1:0]    sym_ff, sym_in;
   logic [lz78dh_pkg::LABEL_W-1:0]  label_ff, label_in;
   logic [lz78dh_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [lz78dh_pkg::LABEL_W:0]    key_parent;
   logic [lz78dh_pkg::SYM_W:0]      key_sym;

   // probe walk
   logic [lz78dh_pkg::ROW_BITS-1:0] step_ff, step_in;
   logic [lz78dh_pkg::ROW_BITS-1:0] slot_ff, slot_in;
   logic [lz78dh_pkg::ROW_BITS-1:0] slot_next;
   logic [lz78dh_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [lz78dh_pkg::ROW_BITS-1:0] clr_ff, clr_in;

   // result being built
   logic                            found_ff, found_in;
   logic [lz78dh_pkg::LABEL_W-1:0]  match_ff, match_in;
   logic                            full_ff, full_in;

   // configuration
   logic                            mode_ff, mode_in;

   // output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [lz78dh_pkg::LABEL_W-1:0]  rsp_match_ff, rsp_match_in;
   logic                            rsp_full_ff, rsp_full_in;

   // RAM ports
   logic                            wr_en;
   logic [lz78dh_pkg::ROW_BITS-1:0] wr_addr;
   lz78dh_pkg::entry_type           wr_entry;
   logic [lz78dh_pkg::ROW_BITS-1:0] rd_addr;
   lz78dh_pkg::entry_type           rd_entry;

   lz78dh_pkg::hash_type            hash;

   // probe decision
   logic req_accept;
   logic rsp_load;
   logic is_search;
   logic slot_used;
   logic key_hit;
   logic last_probe;
   logic probe_end;
   logic probe_fail;
   logic probe_write;
   logic more_roots;

   assign req_stall  = (state_ff != lz78dh_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign mode_in    = (csr_valid && csr_ready) ? csr_wdata : mode_ff;

   // key = (parent + 1) * (symbol + 1), registered ahead of the hash multiply
   assign key_parent = (lz78dh_pkg::LABEL_W + 1)'(parent_in) + (lz78dh_pkg::LABEL_W + 1)'(1);
   assign key_sym    = (lz78dh_pkg::SYM_W + 1)'(sym_in) + (lz78dh_pkg::SYM_W + 1)'(1);
   assign key_in     = lz78dh_pkg::KEY_W'(key_parent) * lz78dh_pkg::KEY_W'(key_sym);

   lz78dh_hash u_hash (
      .key              (key_ff),
      .double_hash_mode (mode_ff),
      .hash             (hash)
   );

   lz78dh_ram #(
      .WIDTH ($bits(lz78dh_pkg::entry_type)),
      .DEPTH (lz78dh_pkg::TABLE_ROWS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   // The slot read last cycle is in rd_entry; an entry with label zero and a
   // non-root parent counts as empty.
   assign is_search   = (op_ff == lz78dh_pkg::CMD_SEARCH);
   assign slot_used   = (rd_entry.label != '0) || (rd_entry.parent == lz78dh_pkg::ROOT_LABEL);
   assign key_hit     = slot_used && (rd_entry.parent == parent_ff) && (rd_entry.symbol == sym_ff);
   assign last_probe  = (count_ff == lz78dh_pkg::COUNT_FULL);
   assign probe_end   = !slot_used || (is_search && key_hit) || last_probe;
   assign probe_fail  = slot_used && !(is_search && key_hit) && last_probe;
   assign probe_write = !is_search && !slot_used;
   assign more_roots  = (op_ff == lz78dh_pkg::CMD_REBUILD) && (sym_ff != lz78dh_pkg::SYM_LAST);
   assign slot_next   = slot_ff + step_ff;

   // Load the output register when it is empty or being drained this cycle.
   assign rsp_load = (state_ff == lz78dh_pkg::ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lz78dh_pkg::ST_CLEAR: begin
            // the sweep ends at the last row; rebuild then reloads the roots
            if (&clr_ff) begin
               state_in = (op_ff == lz78dh_pkg::CMD_REBUILD) ? lz78dh_pkg::ST_HASH
                                                              : lz78dh_pkg::ST_IDLE;
            end
         end
         lz78dh_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (lz78dh_pkg::cmd_type'(req_cmd))
                  lz78dh_pkg::CMD_REBUILD: state_in = lz78dh_pkg::ST_CLEAR;
                  lz78dh_pkg::CMD_NONE:    state_in = lz78dh_pkg::ST_RESP;
                  default:                 state_in = lz78dh_pkg::ST_HASH;
               endcase
            end
         end
         lz78dh_pkg::ST_HASH: begin
            state_in = lz78dh_pkg::ST_PROBE;
         end
         lz78dh_pkg::ST_PROBE: begin
            if (probe_end) begin
               state_in = more_roots ? lz78dh_pkg::ST_HASH : lz78dh_pkg::ST_RESP;
            end
         end
         lz78dh_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = lz78dh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lz78dh_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and RAM control
   always_comb begin
      op_in     = op_ff;
      parent_in = parent_ff;
      sym_in    = sym_ff;
      label_in  = label_ff;
      step_in   = step_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      clr_in    = clr_ff;
      found_in  = found_ff;
      match_in  = match_ff;
      full_in   = full_ff;
      wr_en     = 1'b0;
      wr_addr   = slot_ff;
      wr_entry  = '{parent: parent_ff, symbol: sym_ff, label: label_ff};
      rd_addr   = slot_ff;
      case (state_ff)
         lz78dh_pkg::ST_CLEAR: begin
            // zero one row per cycle
            wr_en    = 1'b1;
            wr_addr  = clr_ff;
            wr_entry = '0;
            clr_in   = clr_ff + lz78dh_pkg::ROW_BITS'(1);
         end
         lz78dh_pkg::ST_IDLE: begin
            if (req_accept) begin
               op_in     = lz78dh_pkg::cmd_type'(req_cmd);
               parent_in = req_parent_label;
               sym_in    = req_symbol;
               label_in  = req_new_label;
               found_in  = 1'b0;
               match_in  = '0;
               full_in   = 1'b0;
               if (lz78dh_pkg::cmd_type'(req_cmd) == lz78dh_pkg::CMD_REBUILD) begin
                  // first root entry: parent root, symbol 0, label 0
                  parent_in = lz78dh_pkg::ROOT_LABEL;
                  sym_in    = '0;
                  label_in  = '0;
                  clr_in    = '0;
               end
            end
         end
         lz78dh_pkg::ST_HASH: begin
            // issue the first probe at the base slot
            rd_addr  = hash.base;
            slot_in  = hash.base;
            step_in  = hash.step;
            count_in = lz78dh_pkg::COUNT_W'(1);
         end
         lz78dh_pkg::ST_PROBE: begin
            // read ahead at the next slot; dropped if this probe ends the walk
            rd_addr  = slot_next;
            slot_in  = slot_next;
            count_in = count_ff + lz78dh_pkg::COUNT_W'(1);
            if (probe_write) begin
               wr_en = 1'b1;
            end
            if (probe_end) begin
               if (is_search) begin
                  found_in = key_hit;
                  match_in = key_hit ? rd_entry.label : '0;
                  full_in  = probe_fail;
               end else begin
                  // rebuild accumulates the full flag over all root inserts
                  full_in = full_ff | probe_fail;
               end
               if (more_roots) begin
                  sym_in   = sym_ff + lz78dh_pkg::SYM_W'(1);
                  label_in = lz78dh_pkg::LABEL_W'(sym_ff) + lz78dh_pkg::LABEL_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // hold the response while stalled, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_match_in = rsp_match_ff;
      rsp_full_in  = rsp_full_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = found_ff;
         rsp_match_in = match_ff;
         rsp_full_in  = full_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lz78dh_pkg::ST_CLEAR;
         op_ff        <= lz78dh_pkg::CMD_SEARCH;
         clr_ff       <= '0;
         count_ff     <= '0;
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      parent_ff    <= parent_in;
      sym_ff       <= sym_in;
      label_ff     <= label_in;
      key_ff       <= key_in;
      step_ff      <= step_in;
      slot_ff      <= slot_in;
      found_ff     <= found_in;
      match_ff     <= match_in;
      full_ff      <= full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_match_ff <= rsp_match_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_label = rsp_match_ff;
   assign rsp_table_full  = rsp_full_ff;

   `LZDH_ASSERT_NOW(a_write_phase, clock, reset, wr_en,
      (state_ff == lz78dh_pkg::ST_CLEAR) || (state_ff == lz78dh_pkg::ST_PROBE))
   `LZDH_ASSERT_NOW(a_search_no_write, clock, reset,
      (state_ff == lz78dh_pkg::ST_PROBE) && (op_ff == lz78dh_pkg::CMD_SEARCH), !wr_en)
   `LZDH_ASSERT_NOW(a_probe_bound, clock, reset, state_ff == lz78dh_pkg::ST_PROBE,
      (count_ff != '0) && (count_ff <= lz78dh_pkg::COUNT_FULL))
   `LZDH_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall,
      state_ff != lz78dh_pkg::ST_IDLE)
   `LZDH_ASSERT_NOW(a_clear_after_reset, clock, reset, $past(reset),
      state_ff == lz78dh_pkg::ST_CLEAR)

endmodule

>>> sim/tb.sv
// Self-checking testbench for the LZ78 dictionary hash table top level.
// Depends on lz78dh_pkg and lz78_dictionary_hash_table_top; runs standalone.
module tb;

   // Idle cycles with no handshake on any channel before the run is abandoned.
   // The longest quiet stretch of a correct run is the RAM sweep after reset or a
   // rebuild plus the longest receiver hold-off.
   localparam int unsigned IDLE_LIMIT  = 100000;
   localparam int unsigned PHASE_ITEMS = 100;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned PRINT_CAP   = 40;

   typedef struct packed {
      logic                          found;
      logic [lz78dh_pkg::LABEL_W-1:0] match_label;
      logic                          table_full;
   } lookup_answer_type;

   typedef struct packed {
      lz78dh_pkg::cmd_type            cmd;
      logic [lz78dh_pkg::LABEL_W-1:0] parent;
      logic [lz78dh_pkg::SYM_W-1:0]   symbol;
      logic [lz78dh_pkg::LABEL_W-1:0] new_label;
      logic                           typed;
      lookup_answer_type              answer;
   } drill_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [1:0]                      req_cmd = 2'd0;
   logic [lz78dh_pkg::LABEL_W-1:0]  req_parent_label = '0;
   logic [lz78dh_pkg::SYM_W-1:0]    req_symbol = '0;
   logic [lz78dh_pkg::LABEL_W-1:0]  req_new_label = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_found;
   logic [lz78dh_pkg::LABEL_W-1:0]  rsp_match_label;
   logic                            rsp_table_full;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic                            csr_wdata = 1'b0;

   // Mirror of the dictionary contents and the probe mode register.
   logic [lz78dh_pkg::LABEL_W-1:0]  dict_parent [lz78dh_pkg::TABLE_ROWS];
   logic [lz78dh_pkg::SYM_W-1:0]    dict_symbol [lz78dh_pkg::TABLE_ROWS];
   logic [lz78dh_pkg::LABEL_W-1:0]  dict_label  [lz78dh_pkg::TABLE_ROWS];
   logic                            double_hash = 1'b1;

   lookup_answer_type   answer_q [$];
   drill_row_type       drill_rows [$];
   int unsigned         mismatches = 0;
   int unsigned         burst_left = 0;
   int unsigned         hold_requests = 0;

   always #2 clock = ~clock;

   lz78_dictionary_hash_table_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_parent_label (req_parent_label),
      .req_symbol       (req_symbol),
      .req_new_label    (req_new_label),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_match_label  (rsp_match_label),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_wdata        (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Dictionary predictor
   // ---------------------------------------------------------------------

   // A slot is free when its label is zero, unless it holds a root symbol.
   function automatic logic slot_taken(input logic [lz78dh_pkg::ROW_BITS-1:0] slot);
      return dict_label[slot] != '0 || dict_parent[slot] == lz78dh_pkg::ROOT_LABEL;
   endfunction

   // Key is (parent+1)*(symbol+1); the base slot is the top ROW_BITS bits of
   // the 0.32 fraction key*golden, the stride depends on the mode register.
   function automatic void probe_start(input logic [lz78dh_pkg::LABEL_W-1:0] parent,
                                       input logic [lz78dh_pkg::SYM_W-1:0] symbol,
                                       output logic [lz78dh_pkg::ROW_BITS-1:0] base,
                                       output logic [lz78dh_pkg::ROW_BITS-1:0] stride);
      logic [31:0] key;
      logic [31:0] frac;
      key  = (32'(parent) + 32'd1) * (32'(symbol) + 32'd1);
      frac = key * lz78dh_pkg::GOLDEN_FRAC;
      base = frac[31 -: lz78dh_pkg::ROW_BITS];
      if (double_hash) begin
         stride = lz78dh_pkg::ROW_BITS'(
                     (key % 32'(lz78dh_pkg::TABLE_ROWS - 1)) | 32'd1);
      end else begin
         stride = lz78dh_pkg::ROW_BITS'(1);
      end
   endfunction

   function automatic lookup_answer_type dict_search(
         input logic [lz78dh_pkg::LABEL_W-1:0] parent,
         input logic [lz78dh_pkg::SYM_W-1:0] symbol);
      lookup_answer_type ans;
      logic [lz78dh_pkg::ROW_BITS-1:0] slot;
      logic [lz78dh_pkg::ROW_BITS-1:0] stride;
      logic done;
      int unsigned n;
      ans  = '0;
      done = 1'b0;
      n    = 0;
      probe_start(parent, symbol, slot, stride);
      while (!done && n < lz78dh_pkg::TABLE_ROWS) begin
         if (!slot_taken(slot)) begin
            done = 1'b1;
         end else if (dict_symbol[slot] == symbol && dict_parent[slot] == parent) begin
            ans.found       = 1'b1;
            ans.match_label = dict_label[slot];
            done            = 1'b1;
         end else begin
            slot += stride;
            n++;
         end
      end
      ans.table_full = !done;
      return ans;
   endfunction

   // Write into the first free slot of the probe sequence; return 1 on no room.
   function automatic logic dict_insert(input logic [lz78dh_pkg::LABEL_W-1:0] parent,
                                        input logic [lz78dh_pkg::SYM_W-1:0] symbol,
                                        input logic [lz78dh_pkg::LABEL_W-1:0] label);
      logic [lz78dh_pkg::ROW_BITS-1:0] slot;
      logic [lz78dh_pkg::ROW_BITS-1:0] stride;
      logic done;
      int unsigned n;
      done = 1'b0;
      n    = 0;
      probe_start(parent, symbol, slot, stride);
      while (!done && n < lz78dh_pkg::TABLE_ROWS) begin
         if (!slot_taken(slot)) begin
            dict_parent[slot] = parent;
            dict_symbol[slot] = symbol;
            dict_label[slot]  = label;
            done              = 1'b1;
         end else begin
            slot += stride;
            n++;
         end
      end
      return !done;
   endfunction

   // Clear every slot of the mirror.
   function automatic void dict_clear();
      int unsigned k;
      for (k = 0; k < lz78dh_pkg::TABLE_ROWS; k++) begin
         dict_parent[k] = '0;
         dict_symbol[k] = '0;
         dict_label[k]  = '0;
      end
   endfunction

   function automatic lookup_answer_type dict_apply(
         input lz78dh_pkg::cmd_type cmd,
         input logic [lz78dh_pkg::LABEL_W-1:0] parent,
         input logic [lz78dh_pkg::SYM_W-1:0] symbol,
         input logic [lz78dh_pkg::LABEL_W-1:0] label);
      lookup_answer_type ans;
      int unsigned k;
      ans = '0;
      case (cmd)
         lz78dh_pkg::CMD_SEARCH: begin
            ans = dict_search(parent, symbol);
         end
         lz78dh_pkg::CMD_INSERT: begin
            ans.table_full = dict_insert(parent, symbol, label);
         end
         lz78dh_pkg::CMD_REBUILD: begin
            dict_clear();
            for (k = 0; k <= lz78dh_pkg::SYM_LAST; k++) begin
               if (dict_insert(lz78dh_pkg::ROOT_LABEL, lz78dh_pkg::SYM_W'(k),
                               lz78dh_pkg::LABEL_W'(k))) ans.table_full = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      end
   endtask

   // Sample on the edge: every value read here is the one from before the edge.
   always @(posedge clock) begin : answer_check
      lookup_answer_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            want = answer_q.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", 32'(rsp_found), 32'(want.found));
            if (rsp_match_label !== want.match_label)
               report_mismatch("match_label", 32'(rsp_match_label), 32'(want.match_label));
            if (rsp_table_full !== want.table_full)
               report_mismatch("table_full", 32'(rsp_table_full), 32'(want.table_full));
         end
      end
   end

   // Count cycles with no handshake anywhere; give up at the limit.
   initial begin : watchdog
      int unsigned idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: stall in stretches of random density, and hold off for a
   // long stretch when the request side asks for it.
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int unsigned stretch;
      int unsigned density;
      int unsigned k;
      int unsigned holds_done;
      holds_done = 0;
      forever begin
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stretch = $urandom_range(8, 64);
            case ($urandom_range(0, 2))
               0: density = 0;
               1: density = 30;
               default: density = 75;
            endcase
            for (k = 0; k < stretch && hold_requests == holds_done; k++) begin
               rsp_stall <= ($urandom_range(0, 99) < density);
               @(posedge clock);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offer one request and hold it until taken, then update the predictor.
   // Valid is left high on return: the caller either offers the next request
   // in the same step or drops valid.
   task automatic issue(input lz78dh_pkg::cmd_type cmd,
                        input logic [lz78dh_pkg::LABEL_W-1:0] parent,
                        input logic [lz78dh_pkg::SYM_W-1:0] symbol,
                        input logic [lz78dh_pkg::LABEL_W-1:0] label,
                        output lookup_answer_type pred);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_parent_label <= parent;
      req_symbol       <= symbol;
      req_new_label    <= label;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = dict_apply(cmd, parent, symbol, label);
   endtask

   // Drain every pending response, then write the probe mode register.
   task automatic write_mode(input logic mode);
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      double_hash = mode;
   endtask

   function automatic drill_row_type mk_row(input lz78dh_pkg::cmd_type cmd,
                                            input int unsigned parent,
                                            input int unsigned symbol,
                                            input int unsigned label,
                                            input int unsigned typed,
                                            input int unsigned found,
                                            input int unsigned match_label);
      drill_row_type r;
      r.cmd                = cmd;
      r.parent             = lz78dh_pkg::LABEL_W'(parent);
      r.symbol             = lz78dh_pkg::SYM_W'(symbol);
      r.new_label          = lz78dh_pkg::LABEL_W'(label);
      r.typed              = (typed != 0);
      r.answer.found       = (found != 0);
      r.answer.match_label = lz78dh_pkg::LABEL_W'(match_label);
      r.answer.table_full  = 1'b0;
      return r;
   endfunction

   initial begin : stimulus
      lookup_answer_type              pred;
      drill_row_type                  row;
      lz78dh_pkg::cmd_type            cmd;
      logic [lz78dh_pkg::LABEL_W-1:0] parent;
      logic [lz78dh_pkg::SYM_W-1:0]   symbol;
      logic [lz78dh_pkg::LABEL_W-1:0] label;
      logic [lz78dh_pkg::LABEL_W-1:0] lz_cur;
      logic [lz78dh_pkg::LABEL_W-1:0] lz_next;
      logic [lz78dh_pkg::LABEL_W-1:0] lz_ins_parent;
      logic [lz78dh_pkg::SYM_W-1:0]   lz_ins_symbol;
      logic                           lz_ins;
      logic                           walk;
      int unsigned                    roll;
      int unsigned                    ph;
      int unsigned                    i;

      // Directed requests. Rows marked typed carry an answer that follows
      // directly from the command; the rest take the predictor's answer.
      // Empty table: every search misses.
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  0,     0,   0,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  16383, 255, 16383, 1, 0, 0));
      // Unused command code answers all zero and changes nothing.
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_NONE,    16383, 255, 16383, 1, 0, 0));
      // Rebuild loads the root symbols with label equal to the symbol.
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_REBUILD, 0,     0,   0,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  256,   0,   0,     1, 1, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  256,   255, 0,     1, 1, 255));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  256,   65,  9,     1, 1, 65));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  65,    66,  257,   1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  65,    66,  0,     1, 1, 257));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  16383, 255, 16383, 1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  16383, 255, 0,     1, 1, 16383));
      // A zero label under a non-root parent leaves the slot looking free.
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  5,     7,   0,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  5,     7,   0,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  5,     7,   300,   1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  5,     7,   0,     1, 1, 300));
      // A duplicate key lands further down the chain; search sees the first.
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  65,    66,  400,   1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  65,    66,  0,     1, 1, 257));
      // A zero label under the root parent still occupies its slot.
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  256,   10,  0,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  256,   10,  0,     1, 1, 10));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_NONE,    0,     0,   0,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  9999,  128, 5555,  0, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  0,     0,   1,     1, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  0,     0,   0,     1, 1, 1));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_INSERT,  10922, 170, 5461,  0, 0, 0));
      drill_rows.push_back(mk_row(lz78dh_pkg::CMD_SEARCH,  10922, 170, 0,     0, 0, 0));

      // Start the mirror from the empty table that reset leaves.
      dict_clear();

      // Hold reset, then set the mode while the block sweeps its RAM.
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b1);

      foreach (drill_rows[k]) begin
         row = drill_rows[k];
         issue(row.cmd, row.parent, row.symbol, row.new_label, pred);
         answer_q.push_back(row.typed ? row.answer : pred);
      end

      // Random phases alternate linear and double-hash probing. Most requests
      // follow an LZ78 encoder: extend the current phrase while the search
      // hits, insert the new phrase on a miss and restart at the root.
      lz_next = lz78dh_pkg::LABEL_W'(257);
      for (ph = 0; ph < 4; ph++) begin
         write_mode(ph[0]);
         lz_cur = lz78dh_pkg::ROOT_LABEL;
         lz_ins = 1'b0;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // Hold off the response side and keep offering back to back.
            if (ph == 2 && i == 20) begin
               hold_requests++;
               burst_left = 12;
            end
            walk   = 1'b0;
            roll   = $urandom_range(0, 99);
            parent = lz78dh_pkg::LABEL_W'($urandom);
            symbol = lz78dh_pkg::SYM_W'($urandom);
            label  = lz78dh_pkg::LABEL_W'($urandom);
            if (i == 0 && !ph[0]) begin
               cmd = lz78dh_pkg::CMD_REBUILD;
            end else if (roll < 78) begin
               if (lz_ins) begin
                  cmd     = lz78dh_pkg::CMD_INSERT;
                  parent  = lz_ins_parent;
                  symbol  = lz_ins_symbol;
                  label   = lz_next;
                  lz_next = (lz_next == '1) ? lz78dh_pkg::LABEL_W'(257) : lz_next + 1'b1;
                  lz_ins  = 1'b0;
                  lz_cur  = lz78dh_pkg::ROOT_LABEL;
               end else begin
                  cmd    = lz78dh_pkg::CMD_SEARCH;
                  parent = lz_cur;
                  if ($urandom_range(0, 99) < 85) begin
                     symbol = lz78dh_pkg::SYM_W'($urandom_range(97, 100));
                  end
                  walk   = 1'b1;
               end
            end else if (roll < 99) begin
               case ($urandom_range(0, 3))
                  0: cmd = lz78dh_pkg::CMD_SEARCH;
                  1: cmd = lz78dh_pkg::CMD_INSERT;
                  2: begin
                     cmd    = lz78dh_pkg::CMD_SEARCH;
                     parent = lz78dh_pkg::ROOT_LABEL;
                  end
                  default: cmd = lz78dh_pkg::CMD_NONE;
               endcase
            end else begin
               cmd = lz78dh_pkg::CMD_REBUILD;
            end
            issue(cmd, parent, symbol, label, pred);
            answer_q.push_back(pred);
            if (walk) begin
               if (pred.found) begin
                  lz_cur = pred.match_label;
               end else begin
                  lz_ins        = 1'b1;
                  lz_ins_parent = parent;
                  lz_ins_symbol = symbol;
               end
            end
         end
      end

      // Drop valid, drain, and leave a margin for any stray response.
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (32) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
